### design/bmp24_stream_to_rgb565_window_defines.svh
// Assertion macros shared by the block
`ifndef BMP24_STREAM_TO_RGB565_WINDOW_DEFINES_SVH
`define BMP24_STREAM_TO_RGB565_WINDOW_DEFINES_SVH

// Check that an implication holds on every clock edge out of reset
`define BSR_ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("check failed");

// Check that an implication holds in the following cycle
`define BSR_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("check failed");

`endif

### design/bsr_pkg.sv
package bsr_pkg;

  localparam int unsigned DispW = 128;
  localparam int unsigned DispH = 128;
  localparam int unsigned MaxW  = 1280;

  // Result kinds
  localparam logic [2:0] KIND_CLEAR  = 3'd0;
  localparam logic [2:0] KIND_WINDOW = 3'd1;
  localparam logic [2:0] KIND_PIXEL  = 3'd2;
  localparam logic [2:0] KIND_DONE   = 3'd3;
  localparam logic [2:0] KIND_REJECT = 3'd4;

  // One result item
  typedef struct packed {
    logic [2:0]  kind;
    logic [6:0]  x_first;
    logic [6:0]  x_last;
    logic [6:0]  row_y;
    logic [15:0] pixel;
    logic        last_of_run;
  } result_t;

  // Bundle of up to three results caused by one byte
  typedef struct packed {
    logic [1:0] cnt;
    result_t    r0;
    result_t    r1;
    result_t    r2;
  } bundle_t;

  localparam int unsigned BundleW = $bits(bundle_t);

endpackage

### design/bsr_parser.sv
// Front part: parse header, seek, skip and draw; turn each byte into a result bundle
module bsr_parser (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               en_i,
  input  logic [7:0]         byte_i,
  input  logic               first_i,
  output logic               push_o,
  output bsr_pkg::bundle_t   bundle_o
);

  localparam logic [2:0] PH_IDLE   = 3'd0;
  localparam logic [2:0] PH_HEADER = 3'd1;
  localparam logic [2:0] PH_SEEK   = 3'd2;
  localparam logic [2:0] PH_SKIP   = 3'd3;
  localparam logic [2:0] PH_DRAW   = 3'd4;
  localparam logic [2:0] PH_DONE   = 3'd5;

  logic [2:0]  ph_q, ph_d;
  logic [31:0] pos_q, pos_d;
  logic [31:0] off_q, off_d;
  logic [31:0] wid_q, wid_d;
  logic [31:0] hgt_q, hgt_d;
  logic [31:0] chk_q, chk_d;
  logic [31:0] skip_q, skip_d;
  logic [11:0] bir_q, bir_d;
  logic [6:0]  row_q, row_d;
  logic [15:0] acc_q, acc_d;
  logic [1:0]  bip_q, bip_d;
  // derived geometry, registered at header end
  logic [11:0] rowb_q, rowb_d;
  logic [11:0] w3_q, w3_d;
  logic [6:0]  xs_q, xs_d;
  logic [6:0]  xe_q, xe_d;
  logic [6:0]  ys_q, ys_d;

  always_comb begin
    logic [2:0]  ph;
    logic [31:0] pos;
    logic [31:0] sw;
    logic        draw;
    logic        skp;
    logic [11:0] bir_n;
    logic [15:0] acc;
    logic [10:0] w11;
    bsr_pkg::result_t rs [3];
    logic [1:0]  n;
    ph_d = ph_q; pos_d = pos_q; off_d = off_q; wid_d = wid_q; hgt_d = hgt_q;
    chk_d = chk_q; skip_d = skip_q; bir_d = bir_q; row_d = row_q; acc_d = acc_q;
    bip_d = bip_q; rowb_d = rowb_q; w3_d = w3_q; xs_d = xs_q; xe_d = xe_q; ys_d = ys_q;
    draw = 1'b0; skp = 1'b0; n = 2'd0; bir_n = '0; acc = '0; sw = '0; w11 = '0;
    for (int i = 0; i < 3; i++) rs[i] = '0;
    ph = ph_q; pos = pos_q;
    if (first_i) begin
      ph = PH_HEADER; pos = '0;
      off_d = '0; wid_d = '0; hgt_d = '0; chk_d = '0; skip_d = '0;
      bir_d = '0; row_d = '0; acc_d = '0; bip_d = '0;
    end
    ph_d = ph; pos_d = pos;
    case (ph)
      PH_HEADER: begin
        if (pos >= 32'd10 && pos <= 32'd13)
          off_d = off_d | ({24'd0, byte_i} << {pos[1:0] - 2'd2, 3'd0});
        else if (pos >= 32'd18 && pos <= 32'd21)
          wid_d = wid_d | ({24'd0, byte_i} << {pos[1:0] - 2'd2, 3'd0});
        else if (pos >= 32'd22 && pos <= 32'd25)
          hgt_d = hgt_d | ({24'd0, byte_i} << {pos[1:0] - 2'd2, 3'd0});
        else if (pos >= 32'd26 && pos <= 32'd29)
          chk_d = chk_d | ({24'd0, byte_i} << {pos[1:0] - 2'd2, 3'd0});
        else if (pos >= 32'd30 && pos <= 32'd33 && byte_i != 8'd0)
          chk_d = '0;
        pos_d = pos + 32'd1;
        if (pos == 32'd33) begin
          n = 2'd1;
          if (chk_d != 32'h0018_0001 || wid_q == '0 || wid_q > 32'(bsr_pkg::MaxW) ||
              hgt_q == '0 || off_q < 32'd34) begin
            rs[0].kind = bsr_pkg::KIND_REJECT;
            ph_d = PH_IDLE;
          end else begin
            rs[0].kind = bsr_pkg::KIND_CLEAR;
            sw = (wid_q > 32'(bsr_pkg::DispW)) ? 32'(bsr_pkg::DispW) : wid_q;
            w11 = wid_q[10:0];
            rowb_d = 12'(({1'b0, w11} * 12'd3 + 12'd3) & ~12'd3);
            w3_d = 12'(sw * 32'd3);
            xs_d = (wid_q > 32'(bsr_pkg::DispW)) ? 7'd0 :
                   7'((32'(bsr_pkg::DispW) - wid_q) >> 1);
            xe_d = 7'(32'(xs_d) + sw - 32'd1);
            ys_d = (hgt_q > 32'(bsr_pkg::DispH)) ? 7'd0 :
                   7'((32'(bsr_pkg::DispH) - hgt_q) >> 1);
            skip_d = (hgt_q > 32'(bsr_pkg::DispH)) ? hgt_q - 32'(bsr_pkg::DispH) : '0;
            row_d = (hgt_q > 32'(bsr_pkg::DispH)) ? 7'(bsr_pkg::DispH - 1) :
                    7'(32'(ys_d) + hgt_q - 32'd1);
            bir_d = '0; bip_d = '0; acc_d = '0;
            ph_d = PH_SEEK;
          end
        end
      end
      PH_SEEK: begin
        if (pos < off_q) pos_d = pos + 32'd1;
        else if (skip_q != '0) begin ph_d = PH_SKIP; skp = 1'b1; end
        else begin ph_d = PH_DRAW; draw = 1'b1; end
      end
      PH_SKIP: skp = 1'b1;
      PH_DRAW: draw = 1'b1;
      default: ;
    endcase
    // skip a padded row of a bottom row that does not fit
    if (skp) begin
      bir_n = bir_q + 12'd1;
      bir_d = bir_n;
      if (bir_n >= rowb_q) begin
        bir_d = '0;
        skip_d = skip_q - 32'd1;
        if (skip_q == 32'd1) ph_d = PH_DRAW;
      end
    end
    // draw: accumulate B,G,R and emit results
    if (draw) begin
      acc = acc_q;
      if (bir_q < w3_q) begin
        case (bip_q)
          2'd0:    acc = {11'd0, byte_i[7:3]};
          2'd1:    acc = acc_q | {5'd0, byte_i[7:2], 5'd0};
          default: acc = acc_q | {byte_i[7:3], 11'd0};
        endcase
        acc_d = acc;
        bip_d = bip_q + 2'd1;
        if (bip_q == 2'd2) begin
          bip_d = '0;
          if (bir_q == 12'd2) begin
            rs[n].kind = bsr_pkg::KIND_WINDOW;
            rs[n].x_first = xs_q; rs[n].x_last = xe_q; rs[n].row_y = row_q;
            n = n + 2'd1;
          end
          rs[n].kind = bsr_pkg::KIND_PIXEL;
          rs[n].pixel = acc;
          n = n + 2'd1;
          if (bir_q == w3_q - 12'd1 && row_q == ys_q) begin
            rs[n].kind = bsr_pkg::KIND_DONE;
            n = n + 2'd1;
            ph_d = PH_DONE;
          end
        end
      end
      if (ph_d != PH_DONE) begin
        bir_n = bir_q + 12'd1;
        bir_d = bir_n;
        if (bir_n >= rowb_q) begin
          bir_d = '0; bip_d = '0; row_d = row_q - 7'd1;
        end
      end
    end
    // mark final result of this byte
    if (n != 2'd0) rs[n - 2'd1].last_of_run = 1'b1;
    push_o = en_i && (n != 2'd0);
    bundle_o.cnt = n;
    bundle_o.r0 = rs[0];
    bundle_o.r1 = rs[1];
    bundle_o.r2 = rs[2];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ph_q <= PH_IDLE; pos_q <= '0; off_q <= '0; wid_q <= '0; hgt_q <= '0;
      chk_q <= '0; skip_q <= '0; bir_q <= '0; row_q <= '0; acc_q <= '0; bip_q <= '0;
      rowb_q <= '0; w3_q <= '0; xs_q <= '0; xe_q <= '0; ys_q <= '0;
    end else if (en_i) begin
      ph_q <= ph_d; pos_q <= pos_d; off_q <= off_d; wid_q <= wid_d; hgt_q <= hgt_d;
      chk_q <= chk_d; skip_q <= skip_d; bir_q <= bir_d; row_q <= row_d;
      acc_q <= acc_d; bip_q <= bip_d; rowb_q <= rowb_d; w3_q <= w3_d;
      xs_q <= xs_d; xe_q <= xe_d; ys_q <= ys_d;
    end
  end

endmodule

### design/bsr_fifo.sv
// Short queue of result bundles between parser and output stage
module bsr_fifo (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_i,
  input  bsr_pkg::bundle_t data_i,
  output logic             full_o,
  output logic             empty_o,
  input  logic             pop_i,
  output bsr_pkg::bundle_t data_o
);

  bsr_pkg::bundle_t mem_q [4];
  logic [1:0] wp_q, rp_q;
  logic [2:0] cnt_q;

  assign full_o  = (cnt_q == 3'd4);
  assign empty_o = (cnt_q == 3'd0);
  assign data_o  = mem_q[rp_q];

  // hold payload slots
  always_ff @(posedge clk_i) begin
    if (push_i) mem_q[wp_q] <= data_i;
  end

  // advance pointers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wp_q <= '0; rp_q <= '0; cnt_q <= '0;
    end else begin
      if (push_i) wp_q <= wp_q + 2'd1;
      if (pop_i)  rp_q <= rp_q + 2'd1;
      cnt_q <= cnt_q + {2'd0, push_i} - {2'd0, pop_i};
    end
  end

endmodule

### design/bsr_emitter.sv
// Back part: unpack each bundle into one to three output transfers
module bsr_emitter (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             empty_i,
  input  bsr_pkg::bundle_t data_i,
  output logic             pop_o,
  output logic             valid_o,
  input  logic             ready_i,
  output bsr_pkg::result_t res_o
);

  logic [1:0] idx_q;
  logic       fire;

  assign valid_o = !empty_i;
  assign fire    = valid_o && ready_i;
  assign pop_o   = fire && (idx_q + 2'd1 == data_i.cnt);

  always_comb begin
    case (idx_q)
      2'd0:    res_o = data_i.r0;
      2'd1:    res_o = data_i.r1;
      default: res_o = data_i.r2;
    endcase
  end

  // advance through the bundle
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) idx_q <= '0;
    else if (fire) idx_q <= pop_o ? 2'd0 : idx_q + 2'd1;
  end

endmodule

### design/bmp24_stream_to_rgb565_window.sv
// BMP 24-bit byte stream to RGB565 window converter. Feed the file one byte per
// transfer, with tuser high on byte 0. The parser handles a byte per clock and
// pushes its one to three results into a four-entry queue, and the output side
// drains one result per cycle while the sink is ready, so a byte that makes
// several results takes one output transfer per result. Input stalls only
// when the queue is full. Results: clear, row window, pixel, done, rejected.
`include "bmp24_stream_to_rgb565_window_defines.svh"
module bmp24_stream_to_rgb565_window (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid_i,
  output logic        s_axis_tready_o,
  input  logic [7:0]  s_axis_tdata_i,  // [7:0] file_byte
  input  logic        s_axis_tuser_i,  // [0] first_byte
  output logic        m_axis_tvalid_o,
  input  logic        m_axis_tready_i,
  output logic [39:0] m_axis_tdata_o,  // [6:0] x_first [13:7] x_last [20:14] row_y [36:21] pixel
  output logic [2:0]  m_axis_tuser_o,  // [2:0] kind
  output logic        m_axis_tlast_o   // last_of_run
);

  logic             full, empty, push, pop, en;
  bsr_pkg::bundle_t bin, bout;
  bsr_pkg::result_t res;

  assign s_axis_tready_o = !full;
  assign en = s_axis_tvalid_i && !full;

  bsr_parser u_parser (
    .clk_i, .rst_ni, .en_i(en), .byte_i(s_axis_tdata_i), .first_i(s_axis_tuser_i),
    .push_o(push), .bundle_o(bin)
  );

  bsr_fifo u_fifo (
    .clk_i, .rst_ni, .push_i(push), .data_i(bin), .full_o(full), .empty_o(empty),
    .pop_i(pop), .data_o(bout)
  );

  bsr_emitter u_emit (
    .clk_i, .rst_ni, .empty_i(empty), .data_i(bout), .pop_o(pop),
    .valid_o(m_axis_tvalid_o), .ready_i(m_axis_tready_i), .res_o(res)
  );

  assign m_axis_tdata_o = {3'd0, res.pixel, res.row_y, res.x_last, res.x_first};
  assign m_axis_tuser_o = res.kind;
  assign m_axis_tlast_o = res.last_of_run;

  `BSR_ASSERT_IMP(a_no_push_full, clk_i, rst_ni, full, !push)
  `BSR_ASSERT_IMP(a_pop_last, clk_i, rst_ni, pop, m_axis_tlast_o)
  `BSR_ASSERT_NEXT(a_full_after_push, clk_i, rst_ni, push && !pop && u_fifo.cnt_q == 3'd3, full)

endmodule
